>>> src/s20sc_pkg.sv
// Shared types, constants and register codes for the Salsa20/20 cipher unit.
`default_nettype none
package s20sc_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
   localparam int HALF_W        = (HALF_ROUNDS > 2) ? $clog2(HALF_ROUNDS) : 1;
   localparam int CHUNKS        = 8;
   localparam int POS_W         = 3;

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   typedef logic [31:0]             word_type;
   typedef logic [3:0][31:0]        lane_type;   // one word per role a,b,c,d
   typedef logic [3:0][3:0][31:0]   grid_type;   // four lanes of four roles
   typedef logic [15:0][31:0]       block_type;  // 16-word state matrix
   typedef logic [63:0]             chunk_type;
   typedef logic [1:0]              step_type;
   typedef logic [HALF_W-1:0]       half_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic [3:0]              count_type;

   typedef enum logic [2:0] {
      CSR_KEY0  = 3'd0,
      CSR_KEY1  = 3'd1,
      CSR_KEY2  = 3'd2,
      CSR_KEY3  = 3'd3,
      CSR_NONCE = 3'd4,
      CSR_CTR   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

endpackage
`default_nettype wire

>>> src/s20sc_arx.sv
// Add-rotate-xor unit: one quarter-round step on all four column lanes.
`default_nettype none
module s20sc_arx (
   input  s20sc_pkg::grid_type grid,
   input  s20sc_pkg::step_type step,
   output s20sc_pkg::lane_type result
);
   import s20sc_pkg::*;

   word_type sum [4];

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         sum[l] = grid[l][0] + grid[l][3];
         case (step)
            2'd0:    result[l] = grid[l][1] ^ {sum[l][24:0], sum[l][31:25]};
            2'd1:    result[l] = grid[l][1] ^ {sum[l][22:0], sum[l][31:23]};
            2'd2:    result[l] = grid[l][1] ^ {sum[l][18:0], sum[l][31:19]};
            default: result[l] = grid[l][1] ^ {sum[l][13:0], sum[l][31:14]};
         endcase
      end
   end

endmodule
`default_nettype wire

>>> src/s20sc_core.sv
// Keystream generator: sequencer around the shared ARX unit, plus the keystream store.
`default_nettype none
module s20sc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  s20sc_pkg::block_type        init_words,
   input  s20sc_pkg::pos_type          rd_pos,
   output s20sc_pkg::chunk_type        ks_chunk,
   output s20sc_pkg::core_status_type  status
);
   import s20sc_pkg::*;

   typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_type;

   cstate_type state_ff, state_in;
   grid_type   grid_ff, grid_in;
   step_type   step_ff, step_in;
   half_type   half_ff, half_in;
   logic       done_ff, done_in;
   chunk_type  ks_ff [CHUNKS];
   chunk_type  ks_in [CHUNKS];

   lane_type   arx_out;
   grid_type   loaded, shifted, turned;
   block_type  sums;

   s20sc_arx u_arx (
      .grid   (grid_ff),
      .step   (step_ff),
      .result (arx_out)
   );

   // lane l role r sits at matrix word (5l + 4r) mod 16
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         for (int r = 0; r < 4; r++) begin
            loaded[l][r] = init_words[(5 * l + 4 * r) & 15];
         end
         shifted[l][0] = arx_out[l];
         shifted[l][1] = grid_ff[l][2];
         shifted[l][2] = grid_ff[l][3];
         shifted[l][3] = grid_ff[l][0];
      end
      // transpose of the matrix, expressed on the lane layout
      for (int l = 0; l < 4; l++) begin
         for (int r = 0; r < 4; r++) begin
            turned[l][r] = shifted[(l + r) & 3][(4 - r) & 3];
         end
      end
      for (int l = 0; l < 4; l++) begin
         for (int r = 0; r < 4; r++) begin
            sums[(5 * l + 4 * r) & 15] = grid_ff[l][r] + init_words[(5 * l + 4 * r) & 15];
         end
      end
      for (int p = 0; p < CHUNKS; p++) begin
         ks_in[p] = {sums[2 * p + 1], sums[2 * p]};
      end
   end

   always_comb begin
      state_in = state_ff;
      grid_in  = grid_ff;
      step_in  = step_ff;
      half_in  = half_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               grid_in  = loaded;
               step_in  = '0;
               half_in  = '0;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               grid_in = turned;
               if (half_ff == half_type'(HALF_ROUNDS - 1)) begin
                  state_in = C_FINAL;
               end else begin
                  half_in = half_ff + half_type'(1);
               end
            end else begin
               grid_in = shifted;
            end
         end
         C_FINAL: begin
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         half_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         half_ff  <= half_in;
      end
      grid_ff <= grid_in;
      if (state_ff == C_FINAL) begin
         for (int p = 0; p < CHUNKS; p++) begin
            ks_ff[p] <= ks_in[p];
         end
      end
   end

   assign ks_chunk    = ks_ff[rd_pos];
   assign status.busy = (state_ff != C_IDLE);
   assign status.done = done_ff;

endmodule
`default_nettype wire

>>> src/salsa20_stream_cipher_unit.sv
// Salsa20/20 stream cipher unit: configuration, transfer control and result register.
//
// Usage: write key, nonce and start counter through csr_we/csr_index/csr_wdata while idle.
// Each req_ transfer carries eight message bytes and a valid count in req_tdata, with
// req_tuser set on the first chunk of a message (reloads the block counter, restarts
// at chunk 0). Each rsp_ transfer returns the XORed bytes (zero beyond the count) and
// the copied count.
// Sequence: a chunk that opens a 64-byte keystream block (chunk position zero, first of
// message, or no block yet) passes through a load step, 4 ARX steps for each of the 20
// half rounds on the shared unit, the final word additions, the hand-back of the done
// flag and the emit step before its result is registered.
// Other chunks go straight from their transfer to the emit step.
// A new chunk is accepted only once the previous one has been emitted; req_tready is
// low while a chunk is in work.
// A finished result waits in the rsp_ register; the next chunk is accepted meanwhile
// and is held at its emit step until rsp_tready frees the register.
// Reset (synchronous, active high) clears the configuration, the block counter, the
// chunk position and the keystream-ready flag, and empties the result register.
`default_nettype none
module salsa20_stream_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // message_bytes[63:0], valid_bytes[67:64], zeros
   input  logic        req_tuser,   // first_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cipher_bytes[63:0], cipher_valid_bytes[67:64], zeros
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import s20sc_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_LOAD, T_GEN, T_EMIT} tstate_type;

   tstate_type      state_ff, state_in;
   logic [63:0]     key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff, start_ff;
   logic [63:0]     ctr_ff, ctr_in;
   pos_type         pos_ff, pos_in;
   logic            ready_ff, ready_in;
   chunk_type       msg_ff, msg_in;
   count_type       cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [71:0]     rsp_data_ff, rsp_data_in;

   block_type       init_words;
   chunk_type       ks_chunk;
   core_status_type core_status;
   chunk_type       cipher;
   logic            req_take;
   logic            out_free;
   logic            first;

   assign init_words = {SIGMA3, key3_ff[63:32], key3_ff[31:0], key2_ff[63:32],
                        key2_ff[31:0], SIGMA2, ctr_ff[63:32], ctr_ff[31:0],
                        nonce_ff[63:32], nonce_ff[31:0], SIGMA1, key1_ff[63:32],
                        key1_ff[31:0], key0_ff[63:32], key0_ff[31:0], SIGMA0};

   s20sc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == T_LOAD),
      .init_words (init_words),
      .rd_pos     (pos_ff),
      .ks_chunk   (ks_chunk),
      .status     (core_status)
   );

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         cipher[8 * i +: 8] = (4'(i) < cnt_ff) ? (msg_ff[8 * i +: 8] ^ ks_chunk[8 * i +: 8])
                                               : 8'h00;
      end
   end

   assign req_tready = (state_ff == T_IDLE) && !reset;
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign first      = req_tuser;

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      pos_in       = pos_ff;
      ready_in     = ready_ff;
      msg_in       = msg_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         T_IDLE: begin
            if (req_take) begin
               msg_in = req_tdata[63:0];
               cnt_in = req_tdata[67:64];
               if (first) begin
                  ctr_in   = start_ff;
                  pos_in   = '0;
                  ready_in = 1'b0;
               end
               if (first || (pos_ff == '0) || !ready_ff) begin
                  state_in = T_LOAD;
               end else begin
                  state_in = T_EMIT;
               end
            end
         end
         T_LOAD: state_in = T_GEN;
         T_GEN: begin
            if (core_status.done) begin
               ctr_in   = ctr_ff + 64'd1;
               ready_in = 1'b1;
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (out_free) begin
               rsp_data_in  = {4'h0, cnt_ff, cipher};
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + pos_type'(1);
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      msg_ff      <= msg_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff  <= '0;
         key1_ff  <= '0;
         key2_ff  <= '0;
         key3_ff  <= '0;
         nonce_ff <= '0;
         start_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY0:  key0_ff  <= csr_wdata;
            CSR_KEY1:  key1_ff  <= csr_wdata;
            CSR_KEY2:  key2_ff  <= csr_wdata;
            CSR_KEY3:  key3_ff  <= csr_wdata;
            CSR_NONCE: nonce_ff <= csr_wdata;
            CSR_CTR:   start_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
